/* rtl/line_rasterizer_defines.svh */
// Assertion macros for the line rasterizer, empty when synthesising.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define LR_ASSERT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("line_rasterizer: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define LR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("line_rasterizer: next-cycle check failed");
`else
`define LR_ASSERT(label, pre, post)
`define LR_ASSERT_NEXT(label, pre, post)
`endif

`endif

/* rtl/lr_pkg.sv */
// Shared types and constants of the line rasterizer.
`timescale 1ns / 1ps
package lr_pkg;

  localparam int unsigned TILE_SIZE   = 64;
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned ERR_W       = 9;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 48;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming command
    logic setup;  // choose axes, order endpoints, form deltas
    logic step;   // emit one pixel and advance
  } lr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic degenerate; // zero-length line at setup
    logic last;       // current pixel is the end point
    logic out_free;   // output register can take a pixel
  } lr_status_t;

  // Saturate a coordinate to the tile
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] c;
    c = v;
    if ({7'd0, c} > 13'(TILE_SIZE - 1)) begin
      c = COORD_W'(TILE_SIZE - 1);
    end
    return c;
  endfunction

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* rtl/lr_ctrl.sv */
// Controller state machine of the line rasterizer.
`timescale 1ns / 1ps
module lr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  lr_pkg::lr_status_t status,
  output lr_pkg::lr_cmd_t    cmd
);
  import lr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_DRAW  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Commands
  assign in_tready = (state_r == ST_IDLE);
  assign cmd.load  = (state_r == ST_IDLE) && in_tvalid;
  assign cmd.setup = (state_r == ST_SETUP);
  assign cmd.step  = (state_r == ST_DRAW) && status.out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        state_nxt = status.degenerate ? ST_IDLE : ST_DRAW;
      end
      ST_DRAW: begin
        if (cmd.step && status.last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/lr_dp.sv */
// Datapath of the line rasterizer: command latch, integer line stepper, output register.
`timescale 1ns / 1ps
module lr_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [lr_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  lr_pkg::lr_cmd_t                cmd,
  output lr_pkg::lr_status_t             status,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import lr_pkg::*;

  // Latched command
  logic [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [COLOR_W-1:0] held_color_r;

  // Line walk state
  logic [COORD_W-1:0]      major_pos_r, major_end_r, minor_pos_r, major_delta_r;
  logic [COORD_W:0]        twice_minor_r;
  logic signed [ERR_W-1:0] error_r;
  logic                    step_down_r, swapped_r;

  // Output register
  logic               out_valid_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_last_r;

  // Setup terms
  logic [COORD_W-1:0] dx, dy, a0, b0, a1, b1, ma0, ma1, mb0, mb1;
  logic               swap_s, order_s;

  // Step terms
  logic signed [ERR_W-1:0] err_sum, err_sub;
  logic                    minor_move;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r         <= clamp_coord(in_tdata[5:0]);
      y0_r         <= clamp_coord(in_tdata[11:6]);
      x1_r         <= clamp_coord(in_tdata[17:12]);
      y1_r         <= clamp_coord(in_tdata[23:18]);
      held_color_r <= in_tdata[55:24];
    end
  end

  // Axis choice and endpoint order
  always_comb begin
    dx      = abs_diff(x0_r, x1_r);
    dy      = abs_diff(y0_r, y1_r);
    swap_s  = dy > dx;
    a0      = swap_s ? y0_r : x0_r;
    b0      = swap_s ? x0_r : y0_r;
    a1      = swap_s ? y1_r : x1_r;
    b1      = swap_s ? x1_r : y1_r;
    order_s = a0 > a1;
    ma0     = order_s ? a1 : a0;
    ma1     = order_s ? a0 : a1;
    mb0     = order_s ? b1 : b0;
    mb1     = order_s ? b0 : b1;
  end

  // Error update for one pixel
  always_comb begin
    err_sum    = error_r + $signed({2'b00, twice_minor_r});
    minor_move = err_sum > $signed({3'b000, major_delta_r});
    err_sub    = err_sum - $signed({2'b00, major_delta_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_pos_r   <= '0;
      major_end_r   <= '0;
      minor_pos_r   <= '0;
      major_delta_r <= '0;
      twice_minor_r <= '0;
      error_r       <= '0;
      step_down_r   <= 1'b0;
      swapped_r     <= 1'b0;
    end else if (cmd.setup) begin
      major_pos_r   <= ma0;
      major_end_r   <= ma1;
      minor_pos_r   <= mb0;
      major_delta_r <= ma1 - ma0;
      twice_minor_r <= {abs_diff(mb0, mb1), 1'b0};
      error_r       <= '0;
      step_down_r   <= mb1 < mb0;
      swapped_r     <= swap_s;
    end else if (cmd.step) begin
      error_r <= minor_move ? err_sub : err_sum;
      if (minor_move) begin
        minor_pos_r <= step_down_r ? (minor_pos_r - 1'b1) : (minor_pos_r + 1'b1);
      end
      if (!status.last) begin
        major_pos_r <= major_pos_r + 1'b1;
      end
    end
  end

  // Output register: valid under reset, payload loaded on each step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_x_r     <= swapped_r ? minor_pos_r : major_pos_r;
      out_y_r     <= swapped_r ? major_pos_r : minor_pos_r;
      out_color_r <= held_color_r;
      out_last_r  <= status.last;
    end
  end

  assign status.degenerate = (ma1 == ma0);
  assign status.last       = (major_pos_r == major_end_r);
  assign status.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_color_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

endmodule

/* rtl/line_rasterizer.sv */
// Top level of the line rasterizer: integer line drawing inside a square tile.
//
//  channel | direction | tdata fields (low bit up)              | tlast
//  in_     | slave     | start_x, start_y, end_x, end_y, color    | -
//  out_    | master    | pixel_x, pixel_y, out_color, 4'b0 pad    | last_pixel
//
//  A line command is accepted, then set up, then drawn at one pixel a cycle along
//  the major axis while the output is free: |major delta| + 1 pixels, up to 64.
//  Coinciding endpoints give no pixel and the block goes from setup back to idle.
//  A low out_tready holds the stepper; the last pixel may wait in the output
//  register while the next command is accepted.
//  rst_n (synchronous, active low) clears the controller, the line walk and the output valid.
`timescale 1ns / 1ps
`include "line_rasterizer_defines.svh"
module line_rasterizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], pixel_color[55:24]
  input  logic [lr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_x[5:0], pixel_y[11:6], out_color[43:12], zero[47:44]
  output logic [lr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import lr_pkg::*;

  lr_cmd_t    cmd;
  lr_status_t status;

  // Controller
  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath
  lr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Checks
  `LR_ASSERT_NEXT(a_accept_leaves_idle, in_tvalid && in_tready, !in_tready)
  `LR_ASSERT(a_mid_line_not_idle, out_tvalid && !out_tlast, !in_tready)
  `LR_ASSERT(a_step_has_room, cmd.step, !out_tvalid || out_tready)

endmodule
